// ----- rtl/ringtone_text_note_parser_assert.svh -----
// assertion macros for the ringtone text note parser
`ifndef RINGTONE_TEXT_NOTE_PARSER_ASSERT_SVH
`define RINGTONE_TEXT_NOTE_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RTNP_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTNP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RTNP_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define RTNP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/rtnp_pkg.sv -----
// shared types, codes and tables of the ringtone text note parser
package rtnp_pkg;
    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_LAST  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_BADHD = 2'd3;

    // job from the parser front to the timing back
    // load set: header end, div carries the tempo for the whole-note division
    typedef struct packed {
        logic        load;
        logic [1:0]  kind;
        logic        mute;
        logic        dot;
        logic [3:0]  semi;
        logic [3:0]  oct;
        logic [15:0] div;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    function automatic logic [8:0] tone_base(input logic [3:0] s);
        logic [8:0] f;
        begin
            unique case (s)
                4'd0:  f = 9'd262;
                4'd1:  f = 9'd277;
                4'd2:  f = 9'd294;
                4'd3:  f = 9'd311;
                4'd4:  f = 9'd330;
                4'd5:  f = 9'd349;
                4'd6:  f = 9'd370;
                4'd7:  f = 9'd392;
                4'd8:  f = 9'd415;
                4'd9:  f = 9'd440;
                4'd10: f = 9'd466;
                4'd11: f = 9'd494;
                4'd12: f = 9'd262;
                4'd13: f = 9'd277;
                4'd14: f = 9'd294;
                default: f = 9'd311;
            endcase
            return f;
        end
    endfunction
endpackage

// ----- rtl/ringtone_text_note_parser.sv -----
// top level of the ringtone text note parser
//  channel | dir | fields (tdata low bit up)            | tuser
//  s_axis  | in  | text_char[7:0]                       | end_marker
//  m_axis  | out | tone_hz[15:0], length_ms[34:16], pad | event_kind[1:0]
// a character is taken in one cycle unless the front stalls; a note loads into the back,
// runs through the restoring divider and is delivered; the back takes no new job meanwhile.
// the parser front stalls only when it has a job and the two-entry job queue is full;
// the header end queues the 240000 / tempo division ahead of the next note.
// reset is synchronous, active low, and returns to skipping the name.
module ringtone_text_note_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_char
    input  logic        s_axis_tuser,   // end_marker
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // tone_hz, length_ms, zero pad
    output logic [1:0]  m_axis_tuser    // event_kind
);
    import rtnp_pkg::*;
`include "ringtone_text_note_parser_assert.svh"

    logic        fj_v, fj_r, bj_v, bj_r;
    t_job        fj, bj;
    logic [15:0] hz;
    logic [18:0] ms;

    rtnp_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_char(s_axis_tdata), .i_end(s_axis_tuser), .o_job_valid(fj_v),
        .i_job_ready(fj_r), .o_job(fj)
    );

    rtnp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(fj_v), .o_ready(fj_r), .i_job(fj),
        .o_valid(bj_v), .i_ready(bj_r), .o_job(bj)
    );

    rtnp_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(bj_v), .o_ready(bj_r), .i_job(bj), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_kind(m_axis_tuser), .o_hz(hz), .o_ms(ms)
    );

    assign m_axis_tdata = {5'b0, ms, hz};

    // checks
    `RTNP_ASSERT_NEVER(a_badhd_quiet, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser == KIND_BADHD && m_axis_tdata != 40'd0,
        "header invalid event with data")
    `RTNP_ASSERT_NEVER(a_silent_end, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser == KIND_END && hz != 16'd0, "end event with tone")
    `RTNP_ASSERT_IMPL(a_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped")
endmodule

// ----- rtl/rtnp_front.sv -----
// character parser: header defaults, note fields, jobs into the queue
module rtnp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char,
    input  logic               i_end,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output rtnp_pkg::t_job     o_job
);
    import rtnp_pkg::*;

    localparam logic [3:0] PH_NAME = 4'd0, PH_HTOP = 4'd1, PH_HWS = 4'd2, PH_HEQ = 4'd3,
        PH_HNUM = 4'd4, PH_NSTART = 4'd5, PH_NDUR = 4'd6, PH_NGAP = 4'd7, PH_TLET = 4'd8,
        PH_TSHARP = 4'd9, PH_TDOT1 = 4'd10, PH_TOCT = 4'd11, PH_TDOT2 = 4'd12,
        PH_TCOMMA = 4'd13, PH_SKIP = 4'd14, PH_DEAD = 4'd15;

    logic [3:0]  r_ph, n_ph;
    logic [15:0] r_acc, n_acc;
    logic [7:0]  r_key, n_key;
    logic [15:0] r_dlen, n_dlen;
    logic [3:0]  r_doct, n_doct;
    logic [15:0] r_tempo, n_tempo;
    logic [15:0] r_ldiv, n_ldiv;
    logic [3:0]  r_semi, n_semi;
    logic [3:0]  r_oct, n_oct;
    logic        r_rest, n_rest, r_dot, n_dot, r_unk, n_unk;

    logic        job_v;
    t_job        job;
    logic [7:0]  c, lc;
    logic        dig, ws, go;
    logic [3:0]  octc;
    logic [15:0] div;

    // one decimal digit into a saturating accumulator
    function automatic logic [15:0] acc_digit(input logic [15:0] a, input logic [3:0] d);
        logic [20:0] m;
        begin
            m = {2'b0, a, 3'b0} + {4'b0, a, 1'b0} + {17'b0, d};
            return (m > 21'd65535) ? 16'hffff : m[15:0];
        end
    endfunction

    assign c    = i_char;
    assign lc   = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    assign dig  = c >= 8'h30 && c <= 8'h39;
    assign ws   = c == 8'h20 || c == 8'h09;
    assign octc = (r_acc > 16'd15) ? 4'd15 : r_acc[3:0];
    assign div  = (r_ldiv != 16'd0) ? r_ldiv : r_dlen;

    // stall whenever a job is pending and the queue is full
    assign o_ready = i_job_ready || !job_v;
    assign go      = i_valid && o_ready;

    // one character walks at most a handful of phases (unrolled, narrow)
    always_comb begin
        logic [3:0]  ph;
        logic        done;
        n_ph = r_ph; n_acc = r_acc; n_key = r_key; n_dlen = r_dlen; n_doct = r_doct;
        n_tempo = r_tempo; n_ldiv = r_ldiv; n_semi = r_semi; n_oct = r_oct;
        n_rest = r_rest; n_dot = r_dot; n_unk = r_unk;
        job_v = 1'b0;
        job = '0;
        ph = r_ph; done = 1'b0;
        if (i_end) begin
            job.oct = r_oct; job.semi = r_semi; job.dot = r_dot;
            job.mute = r_rest | r_unk; job.div = div;
            if (ph <= PH_HNUM) begin
                job_v = 1'b1; job.kind = KIND_BADHD;
            end else if (ph <= PH_NGAP) begin
                job_v = 1'b1; job.kind = KIND_END;
            end else if (ph <= PH_TCOMMA) begin
                job_v = 1'b1; job.kind = KIND_LAST;
                if (ph <= PH_TDOT1) job.oct = r_doct;
                else if (ph == PH_TOCT) job.oct = octc;
            end else if (ph == PH_SKIP) begin
                job_v = 1'b1; job.kind = KIND_LAST; job.mute = 1'b1;
            end
            n_ph = PH_NAME; n_key = '0; n_acc = '0; n_ldiv = '0; n_semi = '0;
            n_oct = '0; n_rest = 1'b0; n_dot = 1'b0; n_unk = 1'b0;
        end else begin
            for (int k = 0; k < 8; k++) begin
                if (!done) begin
                    done = 1'b1;
                    unique case (ph)
                        PH_NAME: if (c == 8'h3a) begin
                            n_dlen = 16'd4; n_doct = 4'd6; n_tempo = 16'd63; ph = PH_HTOP;
                        end
                        PH_HTOP: begin
                            if (c == 8'h3a) begin
                                if (n_tempo == 16'd0) begin
                                    ph = PH_DEAD; job_v = 1'b1; job.kind = KIND_BADHD;
                                end else begin
                                    // whole-note division runs in order with the notes
                                    job_v = 1'b1; job.load = 1'b1; job.div = n_tempo;
                                    ph = PH_NSTART; n_acc = '0; n_ldiv = '0;
                                    n_semi = '0; n_oct = '0;
                                    n_rest = 1'b0; n_dot = 1'b0; n_unk = 1'b0;
                                end
                            end else if (ws) ph = PH_HWS;
                            else begin
                                n_key = lc; n_acc = '0; ph = PH_HEQ;
                            end
                        end
                        PH_HWS: if (!ws) begin
                            n_key = lc; n_acc = '0; ph = PH_HEQ;
                        end
                        PH_HEQ: begin
                            ph = PH_HNUM;
                            if (c != 8'h3d) done = 1'b0;
                        end
                        PH_HNUM: begin
                            if (dig) n_acc = acc_digit(n_acc, c[3:0]);
                            else begin
                                if (n_key == 8'h64) n_dlen = n_acc;
                                else if (n_key == 8'h6f)
                                    n_doct = (n_acc > 16'd15) ? 4'd15 : n_acc[3:0];
                                else if (n_key == 8'h62) n_tempo = n_acc;
                                ph = PH_HTOP;
                                if (c != 8'h2c) done = 1'b0;
                            end
                        end
                        PH_NSTART, PH_NDUR, PH_NGAP: begin
                            if (ph == PH_NDUR && !dig) n_ldiv = n_acc;
                            if (dig && ph != PH_NGAP) begin
                                n_acc = acc_digit(n_acc, c[3:0]); ph = PH_NDUR;
                            end else if (ws) begin
                                if (ph == PH_NDUR) ph = PH_NGAP;
                            end else begin
                                ph = PH_TLET;
                                priority case (lc)
                                    8'h63: n_semi = 4'd0;
                                    8'h64: n_semi = 4'd2;
                                    8'h65: n_semi = 4'd4;
                                    8'h66: n_semi = 4'd5;
                                    8'h67: n_semi = 4'd7;
                                    8'h61: n_semi = 4'd9;
                                    8'h62: n_semi = 4'd11;
                                    8'h70: n_rest = 1'b1;
                                    default: begin
                                        n_unk = 1'b1; ph = PH_SKIP;
                                    end
                                endcase
                            end
                        end
                        PH_TLET: begin
                            ph = PH_TSHARP;
                            if (c == 8'h23) n_semi = n_semi + 4'd1;
                            else done = 1'b0;
                        end
                        PH_TSHARP: begin
                            ph = PH_TDOT1;
                            if (c == 8'h2e) n_dot = 1'b1;
                            else done = 1'b0;
                        end
                        PH_TDOT1: begin
                            if (dig) begin
                                n_acc = {12'b0, c[3:0]}; ph = PH_TOCT;
                            end else begin
                                n_oct = n_doct; ph = PH_TDOT2; done = 1'b0;
                            end
                        end
                        PH_TOCT: begin
                            if (dig) n_acc = acc_digit(n_acc, c[3:0]);
                            else begin
                                n_oct = (n_acc > 16'd15) ? 4'd15 : n_acc[3:0];
                                ph = PH_TDOT2; done = 1'b0;
                            end
                        end
                        PH_TDOT2: begin
                            ph = PH_TCOMMA;
                            if (c == 8'h2e) n_dot = 1'b1;
                            else done = 1'b0;
                        end
                        PH_TCOMMA, PH_SKIP: begin
                            if (ph == PH_TCOMMA || c == 8'h2c || c == 8'h3a) begin
                                job_v = 1'b1; job.kind = KIND_NOTE;
                                job.mute = n_rest | n_unk; job.dot = n_dot;
                                job.semi = n_semi; job.oct = n_oct;
                                job.div = (n_ldiv != 16'd0) ? n_ldiv : n_dlen;
                                n_acc = '0; n_ldiv = '0; n_semi = '0; n_oct = '0;
                                n_rest = 1'b0; n_dot = 1'b0; n_unk = 1'b0;
                                ph = PH_NSTART;
                                if (c != 8'h2c) done = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            n_ph = ph;
        end
    end

    assign o_job_valid  = go && job_v;
    assign o_job        = job;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_NAME; r_acc <= '0; r_key <= '0; r_dlen <= 16'd4; r_doct <= 4'd6;
            r_tempo <= 16'd63; r_ldiv <= '0; r_semi <= '0; r_oct <= '0;
            r_rest <= 1'b0; r_dot <= 1'b0; r_unk <= 1'b0;
        end else if (go) begin
            r_ph <= n_ph; r_acc <= n_acc; r_key <= n_key; r_dlen <= n_dlen;
            r_doct <= n_doct; r_tempo <= n_tempo; r_ldiv <= n_ldiv; r_semi <= n_semi;
            r_oct <= n_oct; r_rest <= n_rest; r_dot <= n_dot; r_unk <= n_unk;
        end
    end
endmodule

// ----- rtl/rtnp_queue.sv -----
// two-entry job queue between parser and timing unit
module rtnp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rtnp_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output rtnp_pkg::t_job o_job
);
    import rtnp_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- rtl/rtnp_back.sv -----
// timing unit: whole-note division, note length division, tone shift
module rtnp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rtnp_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [15:0]    o_hz,
    output logic [18:0]    o_ms
);
    import rtnp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0, ST_WDIV = 2'd1, ST_NDIV = 2'd2, ST_OUT = 2'd3;
    localparam logic [17:0] WHOLE_MS = 18'd240000;

    logic [1:0]  r_st;
    logic [4:0]  r_cnt;
    logic [17:0] r_quo;   // dividend shifting out, quotient shifting in
    logic [15:0] r_rem;
    logic [15:0] r_dvs;
    logic [17:0] r_wnt;
    t_job        r_job;
    logic [1:0]  r_kind;
    logic [15:0] r_hz;
    logic [18:0] r_ms;

    logic [16:0] trial;
    logic [16:0] diff;
    logic [15:0] tone_s;
    logic [23:0] sh;
    logic [18:0] len;

    assign trial   = {r_rem, r_quo[17]};
    assign diff    = trial - {1'b0, r_dvs};
    assign o_ready = r_st == ST_IDLE;
    assign o_valid = r_st == ST_OUT;
    assign o_kind  = r_kind;
    assign o_hz    = r_hz;
    assign o_ms    = r_ms;

    // tone from table shifted by octave
    always_comb begin
        sh = {15'b0, tone_base(r_job.semi)} << r_job.oct;
        sh = sh >> 4;
        tone_s = (sh > 24'd65535) ? 16'hffff : sh[15:0];
    end
    assign len = {1'b0, r_quo} + (r_job.dot ? {2'b0, r_quo[17:1]} : 19'd0);

    // restoring divider, one quotient bit per cycle, finish step at count zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_wnt <= '0;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job; r_rem <= '0; r_cnt <= 5'd18;
                        if (i_job.load) begin
                            r_quo <= WHOLE_MS; r_dvs <= i_job.div; r_st <= ST_WDIV;
                        end else begin
                            r_quo <= r_wnt;
                            r_dvs <= (i_job.div == 16'd0) ? 16'd1 : i_job.div;
                            if (i_job.kind == KIND_END || i_job.kind == KIND_BADHD) begin
                                r_kind <= i_job.kind; r_hz <= '0; r_ms <= '0;
                                r_st <= ST_OUT;
                            end else r_st <= ST_NDIV;
                        end
                    end
                end
                ST_WDIV, ST_NDIV: begin
                    if (r_cnt != 5'd0) begin
                        if (diff[16]) begin
                            r_rem <= trial[15:0]; r_quo <= {r_quo[16:0], 1'b0};
                        end else begin
                            r_rem <= diff[15:0]; r_quo <= {r_quo[16:0], 1'b1};
                        end
                        r_cnt <= r_cnt - 5'd1;
                    end else r_st <= (r_st == ST_WDIV) ? ST_IDLE : ST_OUT;
                end
                ST_OUT: if (i_ready) r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
            if (r_st == ST_WDIV && r_cnt == 5'd0) r_wnt <= r_quo;
            if (r_st == ST_NDIV && r_cnt == 5'd0) begin
                r_kind <= r_job.kind; r_hz <= r_job.mute ? 16'd0 : tone_s; r_ms <= len;
            end
        end
    end
endmodule
